// File: design/typed_slot_pool_allocator_core_macros.svh
// Assertion macros used by the allocator's top level.
`ifndef TYPED_SLOT_POOL_ALLOCATOR_CORE_MACROS_SVH
`define TYPED_SLOT_POOL_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tspa_pkg.sv
// Types and codes shared by the typed slot pool allocator.
`default_nettype none

package tspa_pkg;

	localparam int DATA_W  = 64;
	localparam int SLOT_W  = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_SET   = 2'd2;
	localparam logic [1:0] MODE_GET   = 2'd3;

	localparam logic [1:0] TYPE_NONE  = 2'd0;

	localparam logic [1:0] POOL_COMPLEX = 2'd2;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_TYPE   = 2'd1;
	localparam logic [1:0] STATUS_POOL_FULL  = 2'd2;
	localparam logic [1:0] STATUS_STACK_FULL = 2'd3;

	typedef struct packed {
		logic [1:0]        mode;
		logic [1:0]        value_type;
		logic              type_ok;
		logic [1:0]        pool;
		logic              in_range;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] data_low;
		logic [DATA_W-1:0] data_high;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        result_type;
		logic [SLOT_W-1:0] result_slot;
		logic [DATA_W-1:0] read_low;
		logic [DATA_W-1:0] read_high;
		logic [1:0]        status;
	} result_t;

endpackage

`default_nettype wire

// File: design/tspa_front.sv
// Front end: classifies an incoming word into a command for the back end.
`default_nettype none

module tspa_front #(
	parameter int POOL_DEPTH = 256
) (
	input  wire logic [1:0]               mode,
	input  wire logic [1:0]               value_type,
	input  wire logic [tspa_pkg::SLOT_W-1:0] slot,
	input  wire logic [tspa_pkg::DATA_W-1:0] data_low,
	input  wire logic [tspa_pkg::DATA_W-1:0] data_high,
	output tspa_pkg::cmd_t                cmd
);

	always_comb begin
		cmd.mode       = mode;
		cmd.value_type = value_type;
		cmd.type_ok    = (value_type != tspa_pkg::TYPE_NONE);
		// Pools are numbered from zero; the value is meaningless for type zero.
		cmd.pool       = value_type - 2'd1;
		cmd.in_range   = (32'(slot) < 32'(POOL_DEPTH));
		cmd.slot       = slot;
		cmd.data_low   = data_low;
		cmd.data_high  = data_high;
	end

endmodule

`default_nettype wire

// File: design/tspa_fifo.sv
// Small first-in first-out queue used between the allocator's stages.
`default_nettype none

module tspa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
		return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

// File: design/tspa_back.sv
// Back end: two-step sequencer that runs commands against the counters and slot stores.
`default_nettype none

module tspa_back #(
	parameter int POOL_DEPTH = 256,
	parameter int WORD_WIDTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  tspa_pkg::cmd_t  cmd,
	input  wire logic       cmd_empty,
	output logic            cmd_pop,
	output tspa_pkg::result_t res,
	input  wire logic       res_full,
	output logic            res_push
);

	localparam int AW  = $clog2(POOL_DEPTH);
	localparam int CW  = $clog2(POOL_DEPTH + 1);
	localparam int MAW = $clog2(3 * POOL_DEPTH);
	localparam int SW  = tspa_pkg::SLOT_W;

	localparam logic S_ISSUE  = 1'b0;
	localparam logic S_FINISH = 1'b1;

	logic state_q;

	logic [CW-1:0] fresh_q [3];
	logic [CW-1:0] freed_q [3];

	// Low-word slot stores and freed-slot stacks of all three pools; high words are kept for the complex pool only.
	logic [WORD_WIDTH-1:0] low_mem   [3 * POOL_DEPTH];
	logic [WORD_WIDTH-1:0] high_mem  [POOL_DEPTH];
	logic [SW-1:0]         stack_mem [3 * POOL_DEPTH];

	logic [WORD_WIDTH-1:0] low_rd_q;
	logic [WORD_WIDTH-1:0] high_rd_q;
	logic [SW-1:0]         stack_rd_q;

	tspa_pkg::cmd_t cmd_q;
	logic [1:0]     status_q;
	logic           alloc_ok_q;
	logic           from_stack_q;
	logic           get_hit_q;
	logic [AW-1:0]  fresh_slot_q;

	logic          issue;
	logic [CW-1:0] freed_cur;
	logic [CW-1:0] fresh_cur;
	logic [AW-1:0] cmd_idx;
	logic          is_alloc;
	logic          is_free;
	logic          is_set;
	logic          is_get;
	logic          have_freed;
	logic          have_fresh;
	logic          stack_full;
	logic [1:0]    status_d;
	logic          push_free;
	logic          pop_stack;
	logic          alloc_fresh;
	logic          alloc_q_op;
	logic [AW-1:0] alloc_slot;

	logic                  low_we;
	logic [MAW-1:0]        low_waddr;
	logic [WORD_WIDTH-1:0] low_wdata;
	logic                  high_we;
	logic [AW-1:0]         high_waddr;
	logic [WORD_WIDTH-1:0] high_wdata;

	function automatic logic [MAW-1:0] pool_addr(input logic [1:0] pool,
			input logic [AW-1:0] idx);
		return MAW'(pool) * MAW'(POOL_DEPTH) + MAW'(idx);
	endfunction

	assign issue     = (state_q == S_ISSUE) && !cmd_empty;
	assign cmd_pop   = issue;
	assign res_push  = (state_q == S_FINISH) && !res_full;
	assign freed_cur = freed_q[cmd.pool];
	assign fresh_cur = fresh_q[cmd.pool];
	assign cmd_idx   = AW'(cmd.slot);

	always_comb begin
		is_alloc   = cmd.type_ok && (cmd.mode == tspa_pkg::MODE_ALLOC);
		is_free    = cmd.type_ok && (cmd.mode == tspa_pkg::MODE_FREE);
		is_set     = cmd.type_ok && (cmd.mode == tspa_pkg::MODE_SET);
		is_get     = cmd.type_ok && (cmd.mode == tspa_pkg::MODE_GET);
		have_freed = (freed_cur != '0);
		have_fresh = (fresh_cur < CW'(POOL_DEPTH));
		stack_full = (freed_cur == CW'(POOL_DEPTH));
		pop_stack   = is_alloc && have_freed;
		alloc_fresh = is_alloc && !have_freed && have_fresh;
		push_free   = is_free && !stack_full && cmd.in_range;
		priority if (!cmd.type_ok) begin
			status_d = tspa_pkg::STATUS_BAD_TYPE;
		end else if (is_alloc && !have_freed && !have_fresh) begin
			status_d = tspa_pkg::STATUS_POOL_FULL;
		end else if (is_free && stack_full) begin
			status_d = tspa_pkg::STATUS_STACK_FULL;
		end else begin
			status_d = tspa_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ISSUE;
			for (int i = 0; i < 3; i++) begin
				fresh_q[i] <= '0;
				freed_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_ISSUE: begin
					if (issue) begin
						state_q <= S_FINISH;
						if (pop_stack) begin
							freed_q[cmd.pool] <= freed_cur - CW'(1);
						end else if (alloc_fresh) begin
							fresh_q[cmd.pool] <= fresh_cur + CW'(1);
						end else if (push_free) begin
							freed_q[cmd.pool] <= freed_cur + CW'(1);
						end
					end
				end
				S_FINISH: begin
					if (res_push) begin
						state_q <= S_ISSUE;
					end
				end
				default: begin
					state_q <= S_ISSUE;
				end
			endcase
		end
	end

	// Command context held for the finishing step.
	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_q        <= cmd;
			status_q     <= status_d;
			alloc_ok_q   <= pop_stack || alloc_fresh;
			from_stack_q <= have_freed;
			get_hit_q    <= is_get && cmd.in_range;
			fresh_slot_q <= AW'(fresh_cur);
		end
	end

	always_ff @(posedge clk) begin
		if (issue && push_free) begin
			stack_mem[pool_addr(cmd.pool, AW'(freed_cur))] <= cmd.slot;
		end
		if (issue && pop_stack) begin
			stack_rd_q <= stack_mem[pool_addr(cmd.pool, AW'(freed_cur - CW'(1)))];
		end
	end

	assign alloc_q_op = cmd_q.type_ok && (cmd_q.mode == tspa_pkg::MODE_ALLOC);
	assign alloc_slot = from_stack_q ? AW'(stack_rd_q) : fresh_slot_q;

	// A set writes during issue; an allocation writes when its result leaves.
	always_comb begin
		if (state_q == S_ISSUE) begin
			low_we     = issue && is_set && cmd.in_range;
			low_waddr  = pool_addr(cmd.pool, cmd_idx);
			low_wdata  = cmd.data_low[WORD_WIDTH-1:0];
			high_we    = low_we && (cmd.pool == tspa_pkg::POOL_COMPLEX);
			high_waddr = cmd_idx;
			high_wdata = cmd.data_high[WORD_WIDTH-1:0];
		end else begin
			low_we     = res_push && alloc_q_op && alloc_ok_q;
			low_waddr  = pool_addr(cmd_q.pool, alloc_slot);
			low_wdata  = cmd_q.data_low[WORD_WIDTH-1:0];
			high_we    = low_we && (cmd_q.pool == tspa_pkg::POOL_COMPLEX);
			high_waddr = alloc_slot;
			high_wdata = cmd_q.data_high[WORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (low_we) begin
			low_mem[low_waddr] <= low_wdata;
		end
		if (issue && is_get && cmd.in_range) begin
			low_rd_q <= low_mem[pool_addr(cmd.pool, cmd_idx)];
		end
	end

	always_ff @(posedge clk) begin
		if (high_we) begin
			high_mem[high_waddr] <= high_wdata;
		end
		if (issue && is_get && cmd.in_range && (cmd.pool == tspa_pkg::POOL_COMPLEX)) begin
			high_rd_q <= high_mem[cmd_idx];
		end
	end

	always_comb begin
		res.result_type = cmd_q.type_ok ? cmd_q.value_type : tspa_pkg::TYPE_NONE;
		if (alloc_q_op) begin
			res.result_slot = alloc_ok_q ? SW'(alloc_slot) : '0;
		end else begin
			res.result_slot = cmd_q.slot;
		end
		res.read_low  = get_hit_q ? tspa_pkg::DATA_W'(low_rd_q) : '0;
		res.read_high = (get_hit_q && (cmd_q.pool == tspa_pkg::POOL_COMPLEX)) ?
			tspa_pkg::DATA_W'(high_rd_q) : '0;
		res.status    = status_q;
	end

endmodule

`default_nettype wire

// File: design/typed_slot_pool_allocator_core.sv
// Top level of the typed slot pool allocator.
// Keeps integer, real and complex value pools, each with POOL_DEPTH slots, a fresh-slot
// counter and a stack of freed slots. Words go in through a queue-like push/full port and
// results come out through an empty/pop port, one result per input word, in order. The
// front end classifies each word into a command queue of two entries; the back end runs
// each command as an issue step (which reads and updates the pool counters and
// starts the registered read of a slot store or freed-slot stack) and then a finishing step
// that completes the store write and hands the result to a two-entry result queue; it
// takes no new command until the last result has been handed over, and the handover waits
// while the result queue is full. Nothing needs clearing after reset.
`default_nettype none

`include "typed_slot_pool_allocator_core_macros.svh"

module typed_slot_pool_allocator_core #(
	parameter int POOL_DEPTH = 256,
	parameter int WORD_WIDTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  mode,
	input  wire logic [1:0]  value_type,
	input  wire logic [7:0]  slot,
	input  wire logic [63:0] data_low,
	input  wire logic [63:0] data_high,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       result_type,
	output logic [7:0]       result_slot,
	output logic [63:0]      read_low,
	output logic [63:0]      read_high,
	output logic [1:0]       status
);

	localparam int CMD_W = $bits(tspa_pkg::cmd_t);
	localparam int RES_W = $bits(tspa_pkg::result_t);

	tspa_pkg::cmd_t    front_cmd;
	tspa_pkg::cmd_t    back_cmd;
	tspa_pkg::result_t back_res;
	tspa_pkg::result_t out_res;

	logic [CMD_W-1:0] cmd_dout;
	logic [RES_W-1:0] res_dout;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_full;
	logic             res_push;

	tspa_front #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_front (
		.mode      (mode),
		.value_type(value_type),
		.slot      (slot),
		.data_low  (data_low),
		.data_high (data_high),
		.cmd       (front_cmd)
	);

	tspa_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(tspa_pkg::QUEUE_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (front_cmd),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (cmd_dout),
		.empty (cmd_empty)
	);

	assign back_cmd = tspa_pkg::cmd_t'(cmd_dout);

	tspa_back #(
		.POOL_DEPTH(POOL_DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (back_cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res      (back_res),
		.res_full (res_full),
		.res_push (res_push)
	);

	tspa_fifo #(
		.WIDTH(RES_W),
		.DEPTH(tspa_pkg::QUEUE_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (back_res),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_dout),
		.empty (empty)
	);

	assign out_res     = tspa_pkg::result_t'(res_dout);
	assign result_type = out_res.result_type;
	assign result_slot = out_res.result_slot;
	assign read_low    = out_res.read_low;
	assign read_high   = out_res.read_high;
	assign status      = out_res.status;

	// The sequencer never takes a command while a result is being handed over,
	// and never takes two commands in consecutive cycles.
	`TSPA_ASSERT_SAME(a_pop_has_cmd, clk, arst_n, cmd_pop, !cmd_empty, "command taken from empty queue")
	`TSPA_ASSERT_SAME(a_push_has_room, clk, arst_n, res_push, !res_full, "result pushed into full queue")
	`TSPA_ASSERT_NEXT(a_two_step, clk, arst_n, cmd_pop, !cmd_pop, "commands taken in consecutive cycles")
	`TSPA_ASSERT_SAME(a_issue_or_finish, clk, arst_n, res_push, !cmd_pop, "issue and finish in one cycle")

endmodule

`default_nettype wire
